>>> rtl/rcc_pkg.sv
// Shared codes, result types and helpers for the registration and call controller.
package rcc_pkg;

    localparam int MAX_RES = 3;

    // input kinds (s_tuser)
    localparam logic [2:0] KIND_RX      = 3'd0;
    localparam logic [2:0] KIND_REG     = 3'd1;
    localparam logic [2:0] KIND_DEREG   = 3'd2;
    localparam logic [2:0] KIND_CALL    = 3'd3;
    localparam logic [2:0] KIND_HANGUP  = 3'd4;
    localparam logic [2:0] KIND_ANSWER  = 3'd5;
    localparam logic [2:0] KIND_TICK    = 3'd6;

    // received message type bytes
    localparam logic [7:0] MT_AUTH_CMD  = 8'h02;
    localparam logic [7:0] MT_REG_RSP   = 8'h03;
    localparam logic [7:0] MT_DEREG_REQ = 8'h04;
    localparam logic [7:0] MT_DEREG_RSP = 8'h05;
    localparam logic [7:0] MT_SETUP     = 8'h06;
    localparam logic [7:0] MT_SETUP_ACK = 8'h07;
    localparam logic [7:0] MT_ALERTING  = 8'h08;
    localparam logic [7:0] MT_CONNECT   = 8'h09;
    localparam logic [7:0] MT_CONN_ACK  = 8'h0a;
    localparam logic [7:0] MT_REL_REQ   = 8'h0c;

    // registration states
    localparam logic [1:0] R_UNREG = 2'd0;
    localparam logic [1:0] R_AUTH  = 2'd1;
    localparam logic [1:0] R_REG   = 2'd2;

    // call states
    localparam logic [3:0] C_IDLE      = 4'd0;
    localparam logic [3:0] C_INIT      = 4'd1;
    localparam logic [3:0] C_PROC      = 4'd2;
    localparam logic [3:0] C_DELIV     = 4'd3;
    localparam logic [3:0] C_PRES      = 4'd4;
    localparam logic [3:0] C_RECV      = 4'd5;
    localparam logic [3:0] C_CONREQ    = 4'd6;
    localparam logic [3:0] C_CONF      = 4'd7;
    localparam logic [3:0] C_ACTIVE    = 4'd8;
    localparam logic [3:0] C_RELEASING = 4'd9;

    // messages to send
    localparam logic [3:0] M_NONE     = 4'd0;
    localparam logic [3:0] M_REG      = 4'd1;
    localparam logic [3:0] M_AUTHREG  = 4'd2;
    localparam logic [3:0] M_DEREGREQ = 4'd3;
    localparam logic [3:0] M_DEREGRSP = 4'd4;
    localparam logic [3:0] M_SETUP    = 4'd5;
    localparam logic [3:0] M_SETUPACK = 4'd6;
    localparam logic [3:0] M_ALERT    = 4'd7;
    localparam logic [3:0] M_CONNECT  = 4'd8;
    localparam logic [3:0] M_CONNACK  = 4'd9;
    localparam logic [3:0] M_DISC     = 4'd10;
    localparam logic [3:0] M_RELRSP   = 4'd11;

    // causes
    localparam logic [7:0] CAUSE_NORMAL    = 8'd27;
    localparam logic [7:0] CAUSE_REJECT    = 8'd26;
    localparam logic [7:0] CAUSE_NO_ANSWER = 8'd6;

    localparam logic [31:0] CALL_ID_NONE = 32'hffff_ffff;

    // configuration register indexes
    localparam logic CFG_SHORT = 1'b0;
    localparam logic CFG_ALERT = 1'b1;

    localparam logic [15:0] SHORT_TICKS_RST = 16'd5000;
    localparam logic [15:0] ALERT_TICKS_RST = 16'd30000;

    typedef struct packed {
        logic [7:0]  cause;
        logic [31:0] id;
        logic [3:0]  msg;
    } rcc_res_t;

    // all results of one request, plus states after it
    typedef struct packed {
        logic [3:0]                 call_status;
        logic [1:0]                 reg_status;
        logic [1:0]                 count;
        rcc_res_t [MAX_RES-1:0]     res;
    } rcc_batch_t;

    function automatic rcc_batch_t push_res(rcc_batch_t b, logic [3:0] msg,
                                            logic [31:0] id, logic [7:0] cause);
        rcc_batch_t r;
        r = b;
        if (b.count < 2'(MAX_RES))
        begin
            r.res[b.count].msg   = msg;
            r.res[b.count].id    = id;
            r.res[b.count].cause = cause;
            r.count              = b.count + 2'd1;
        end
        return r;
    endfunction

endpackage

>>> rtl/rcc_ctrl.sv
// Registration and call state registers, timers and per-request next-state logic.
module rcc_ctrl #(
    parameter int TIMER_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [2:0]        kind,
    input  logic [7:0]        msg_type,
    input  logic [31:0]       call_id,
    input  logic [15:0]       short_ticks,
    input  logic [15:0]       alert_ticks,
    output rcc_pkg::rcc_batch_t batch
);
    import rcc_pkg::*;

    localparam int NUM_TIMERS = 6;
    localparam int T_REG    = 0;
    localparam int T_SETUP  = 1;
    localparam int T_ALERT  = 2;
    localparam int T_ANSWER = 3;
    localparam int T_DISC   = 4;
    localparam int T_CONN   = 5;

    logic [1:0]            reg_phase_reg, reg_phase_next;
    logic [3:0]            call_phase_reg, call_phase_next;
    logic [1:0]            init_rs_reg, init_rs_next;
    logic [1:0]            auth_rs_reg, auth_rs_next;
    logic [1:0]            dereg_rs_reg, dereg_rs_next;
    logic [1:0]            conn_rs_reg, conn_rs_next;
    logic                  disc_rs_reg, disc_rs_next;
    logic [TIMER_BITS-1:0] tcnt_reg [NUM_TIMERS];
    logic [TIMER_BITS-1:0] tcnt_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] trun_reg, trun_next;
    logic [NUM_TIMERS-1:0] due;
    logic [31:0]           call_id_reg, call_id_next;
    logic [7:0]            cause_reg, cause_next;
    logic [TIMER_BITS-1:0] short_load, alert_load;
    rcc_batch_t            b;

    assign short_load = TIMER_BITS'(short_ticks);
    assign alert_load = TIMER_BITS'(alert_ticks);

    always_comb
    begin
        reg_phase_next  = reg_phase_reg;
        call_phase_next = call_phase_reg;
        init_rs_next    = init_rs_reg;
        auth_rs_next    = auth_rs_reg;
        dereg_rs_next   = dereg_rs_reg;
        conn_rs_next    = conn_rs_reg;
        disc_rs_next    = disc_rs_reg;
        tcnt_next       = tcnt_reg;
        trun_next       = trun_reg;
        due             = '0;
        call_id_next    = call_id_reg;
        cause_next      = cause_reg;
        b               = '0;

        unique case (kind)
            KIND_RX:
            begin
                // any received message stops the registration timer
                tcnt_next[T_REG] = '0; trun_next[T_REG] = 1'b0;
                priority if (msg_type == MT_AUTH_CMD && reg_phase_next == R_UNREG)
                begin
                    reg_phase_next = R_AUTH;
                    tcnt_next[T_REG] = short_load; trun_next[T_REG] = 1'b1;
                    b = push_res(b, M_AUTHREG, '0, '0);
                end
                else if (msg_type == MT_REG_RSP && reg_phase_next == R_AUTH)
                begin
                    reg_phase_next  = R_REG;
                    call_phase_next = C_IDLE;
                end
                else if (msg_type == MT_DEREG_REQ && reg_phase_next == R_REG)
                begin
                    b = push_res(b, M_DEREGRSP, '0, '0);
                    reg_phase_next  = R_UNREG;
                    call_phase_next = C_IDLE;
                    init_rs_next = '0; auth_rs_next = '0; dereg_rs_next = '0;
                    conn_rs_next = '0; disc_rs_next = 1'b0;
                end
                else if (msg_type == MT_DEREG_RSP && reg_phase_next == R_REG)
                begin
                    reg_phase_next  = R_UNREG;
                    call_phase_next = C_IDLE;
                    init_rs_next = '0; auth_rs_next = '0; dereg_rs_next = '0;
                    conn_rs_next = '0; disc_rs_next = 1'b0;
                end
                else if (msg_type == MT_SETUP && call_phase_next == C_IDLE
                         && reg_phase_next == R_REG)
                begin
                    call_id_next = call_id;
                    b = push_res(b, M_SETUPACK, call_id, '0);
                    b = push_res(b, M_ALERT, call_id, '0);
                    call_phase_next = C_RECV;
                end
                else if (msg_type == MT_SETUP_ACK && call_phase_next == C_INIT)
                begin
                    call_phase_next = C_PROC;
                    tcnt_next[T_SETUP] = '0; trun_next[T_SETUP] = 1'b0;
                    call_id_next = call_id;
                    tcnt_next[T_ALERT] = short_load; trun_next[T_ALERT] = 1'b1;
                end
                else if (msg_type == MT_ALERTING && call_phase_next == C_PROC)
                begin
                    call_phase_next = C_DELIV;
                    tcnt_next[T_ALERT] = '0; trun_next[T_ALERT] = 1'b0;
                    tcnt_next[T_SETUP] = '0; trun_next[T_SETUP] = 1'b0;
                    tcnt_next[T_ANSWER] = alert_load; trun_next[T_ANSWER] = 1'b1;
                end
                else if (msg_type == MT_CONNECT
                         && (call_phase_next == C_DELIV || call_phase_next == C_PROC))
                begin
                    call_phase_next = C_ACTIVE;
                    tcnt_next[T_ANSWER] = '0; trun_next[T_ANSWER] = 1'b0;
                    tcnt_next[T_SETUP]  = '0; trun_next[T_SETUP]  = 1'b0;
                    tcnt_next[T_ALERT]  = '0; trun_next[T_ALERT]  = 1'b0;
                    b = push_res(b, M_CONNACK, call_id_next, '0);
                end
                else if (msg_type == MT_CONN_ACK && call_phase_next == C_CONREQ)
                begin
                    call_phase_next = C_ACTIVE;
                    tcnt_next[T_CONN] = '0; trun_next[T_CONN] = 1'b0;
                    conn_rs_next = '0; disc_rs_next = 1'b0;
                end
                else if (msg_type == MT_REL_REQ)
                begin
                    call_phase_next = C_IDLE;
                    conn_rs_next = '0; disc_rs_next = 1'b0;
                    for (int i = T_SETUP; i < NUM_TIMERS; i++)
                    begin
                        tcnt_next[i] = '0; trun_next[i] = 1'b0;
                    end
                    b = push_res(b, M_RELRSP, call_id_next, CAUSE_NORMAL);
                end
                else
                begin
                    // unknown type or wrong state: nothing more
                end
            end
            KIND_REG:
            begin
                if (reg_phase_next == R_UNREG)
                begin
                    tcnt_next[T_REG] = short_load; trun_next[T_REG] = 1'b1;
                    b = push_res(b, M_REG, '0, '0);
                end
            end
            KIND_DEREG:
            begin
                if (reg_phase_next == R_REG)
                begin
                    tcnt_next[T_REG] = short_load; trun_next[T_REG] = 1'b1;
                    b = push_res(b, M_DEREGREQ, '0, '0);
                end
            end
            KIND_CALL:
            begin
                if (reg_phase_next == R_REG && call_phase_next == C_IDLE)
                begin
                    call_phase_next = C_INIT;
                    tcnt_next[T_SETUP] = short_load; trun_next[T_SETUP] = 1'b1;
                    b = push_res(b, M_SETUP, CALL_ID_NONE, '0);
                end
            end
            KIND_HANGUP:
            begin
                if (call_phase_next == C_DELIV || call_phase_next == C_ACTIVE
                    || call_phase_next == C_RECV)
                begin
                    // delivered keeps the previous cause
                    if (call_phase_next == C_ACTIVE)
                        cause_next = CAUSE_NORMAL;
                    else if (call_phase_next == C_RECV)
                        cause_next = CAUSE_REJECT;
                    disc_rs_next = 1'b0;
                    tcnt_next[T_ANSWER] = '0; trun_next[T_ANSWER] = 1'b0;
                    tcnt_next[T_DISC] = short_load; trun_next[T_DISC] = 1'b1;
                    call_phase_next = C_RELEASING;
                    b = push_res(b, M_DISC, call_id_next, cause_next);
                end
            end
            KIND_ANSWER:
            begin
                if (call_phase_next == C_RECV)
                begin
                    tcnt_next[T_CONN] = short_load; trun_next[T_CONN] = 1'b1;
                    call_phase_next = C_CONREQ;
                    b = push_res(b, M_CONNECT, call_id_next, '0);
                end
            end
            KIND_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (trun_reg[i])
                    begin
                        if (tcnt_reg[i] <= TIMER_BITS'(1))
                        begin
                            tcnt_next[i] = '0;
                            due[i]       = 1'b1;
                        end
                        else
                            tcnt_next[i] = tcnt_reg[i] - TIMER_BITS'(1);
                    end
                end

                // handlers in fixed order; a stop clears the due flag of that timer
                if (due[T_REG])
                begin
                    tcnt_next[T_REG] = '0; trun_next[T_REG] = 1'b0; due[T_REG] = 1'b0;
                    if (reg_phase_next == R_UNREG && init_rs_next <= 2'd1)
                    begin
                        init_rs_next = init_rs_next + 2'd1;
                        tcnt_next[T_REG] = short_load; trun_next[T_REG] = 1'b1;
                        b = push_res(b, M_REG, '0, '0);
                    end
                    else if (reg_phase_next == R_AUTH && auth_rs_next <= 2'd1)
                    begin
                        auth_rs_next = auth_rs_next + 2'd1;
                        tcnt_next[T_REG] = short_load; trun_next[T_REG] = 1'b1;
                        b = push_res(b, M_AUTHREG, '0, '0);
                    end
                    else if (reg_phase_next == R_REG && dereg_rs_next <= 2'd1)
                    begin
                        dereg_rs_next = dereg_rs_next + 2'd1;
                        tcnt_next[T_REG] = short_load; trun_next[T_REG] = 1'b1;
                        b = push_res(b, M_DEREGREQ, '0, '0);
                    end
                    else
                    begin
                        // give up: call timers keep running
                        reg_phase_next  = R_UNREG;
                        call_phase_next = C_IDLE;
                        init_rs_next = '0; auth_rs_next = '0; dereg_rs_next = '0;
                        conn_rs_next = '0; disc_rs_next = 1'b0;
                    end
                end

                for (int i = T_SETUP; i <= T_ANSWER; i++)
                begin
                    if (due[i])
                    begin
                        for (int j = T_SETUP; j <= T_ANSWER; j++)
                        begin
                            tcnt_next[j] = '0; trun_next[j] = 1'b0; due[j] = 1'b0;
                        end
                        call_phase_next = C_IDLE;
                        conn_rs_next = '0; disc_rs_next = 1'b0;
                    end
                end

                if (due[T_DISC])
                begin
                    tcnt_next[T_DISC] = '0; trun_next[T_DISC] = 1'b0; due[T_DISC] = 1'b0;
                    if (!disc_rs_next)
                    begin
                        disc_rs_next = 1'b1;
                        tcnt_next[T_DISC] = short_load; trun_next[T_DISC] = 1'b1;
                        b = push_res(b, M_DISC, call_id_next, cause_next);
                    end
                    else
                    begin
                        call_phase_next = C_IDLE;
                        conn_rs_next = '0; disc_rs_next = 1'b0;
                        for (int i = T_SETUP; i < NUM_TIMERS; i++)
                        begin
                            tcnt_next[i] = '0; trun_next[i] = 1'b0; due[i] = 1'b0;
                        end
                    end
                end

                if (due[T_CONN])
                begin
                    tcnt_next[T_CONN] = '0; trun_next[T_CONN] = 1'b0; due[T_CONN] = 1'b0;
                    if (conn_rs_next <= 2'd1)
                    begin
                        conn_rs_next = conn_rs_next + 2'd1;
                        tcnt_next[T_CONN] = short_load; trun_next[T_CONN] = 1'b1;
                        b = push_res(b, M_CONNECT, call_id_next, '0);
                    end
                    else
                    begin
                        conn_rs_next = '0; disc_rs_next = 1'b0;
                        cause_next = CAUSE_NO_ANSWER;
                        tcnt_next[T_DISC] = short_load; trun_next[T_DISC] = 1'b1;
                        call_phase_next = C_RELEASING;
                        b = push_res(b, M_DISC, call_id_next, cause_next);
                    end
                end
            end
            default:
            begin
                // unused kind: no effect
            end
        endcase

        if (b.count == 2'd0)
            b = push_res(b, M_NONE, '0, '0);
        b.reg_status  = reg_phase_next;
        b.call_status = call_phase_next;
    end

    assign batch = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_phase_reg  <= R_UNREG;
            call_phase_reg <= C_IDLE;
            init_rs_reg    <= '0;
            auth_rs_reg    <= '0;
            dereg_rs_reg   <= '0;
            conn_rs_reg    <= '0;
            disc_rs_reg    <= 1'b0;
            trun_reg       <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
                tcnt_reg[i] <= '0;
            call_id_reg    <= CALL_ID_NONE;
            cause_reg      <= CAUSE_NORMAL;
        end
        else if (step)
        begin
            reg_phase_reg  <= reg_phase_next;
            call_phase_reg <= call_phase_next;
            init_rs_reg    <= init_rs_next;
            auth_rs_reg    <= auth_rs_next;
            dereg_rs_reg   <= dereg_rs_next;
            conn_rs_reg    <= conn_rs_next;
            disc_rs_reg    <= disc_rs_next;
            trun_reg       <= trun_next;
            tcnt_reg       <= tcnt_next;
            call_id_reg    <= call_id_next;
            cause_reg      <= cause_next;
        end
    end

endmodule

>>> rtl/rcc_outq.sv
// Result register holding one request's results and handing them out one per cycle while m_tready is high.
module rcc_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  rcc_pkg::rcc_batch_t batch,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,   // send_message, out_call_id, out_cause,
                                           // reg_status, call_status, zero pad
    output logic                m_tlast
);
    import rcc_pkg::*;

    rcc_batch_t batch_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       at_end;
    rcc_res_t   cur;

    assign at_end = (idx_reg == batch_reg.count - 2'd1);
    assign free   = !valid_reg || (m_tready && at_end);
    assign cur    = batch_reg.res[idx_reg];

    assign m_tvalid = valid_reg;
    assign m_tlast  = at_end;
    assign m_tdata  = {6'd0, batch_reg.call_status, batch_reg.reg_status,
                       cur.cause, cur.id, cur.msg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && m_tready)
        begin
            if (at_end)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            batch_reg <= batch;
    end

endmodule

>>> rtl/registration_and_call_control_fsm.sv
// Top level of the terminal registration and call control block.
// Each request (received message, user action or tick) is registered, then handled
// combinationally and its one to three results go into a result register that drives the
// master side one result per cycle while m_tready is high, m_tlast marking the last. The
// input register takes the next request while the results drain and hands it on at the
// edge that takes the last result. m_tvalid rises once the request has passed the input
// register and been loaded into the result register. Timer values are to be written
// through the cfg port only while idle; the block itself does not enforce this.
module registration_and_call_control_fsm #(
    parameter int TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // msg_type, call_id
    input  logic [2:0]  s_tuser,    // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // send_message, out_call_id, out_cause,
                                    // reg_status, call_status, zero pad
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import rcc_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  msg_type_reg;
    logic [31:0] call_id_reg;
    logic [15:0] short_ticks_reg;
    logic [15:0] alert_ticks_reg;
    logic        free;
    logic        step;
    rcc_batch_t  batch;

    assign step      = in_valid_reg && free;
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg     <= s_tuser;
            msg_type_reg <= s_tdata[7:0];
            call_id_reg  <= s_tdata[39:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ticks_reg <= SHORT_TICKS_RST;
            alert_ticks_reg <= ALERT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SHORT: short_ticks_reg <= cfg_data;
                CFG_ALERT: alert_ticks_reg <= cfg_data;
            endcase
        end
    end

    rcc_ctrl #(
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .kind        (kind_reg),
        .msg_type    (msg_type_reg),
        .call_id     (call_id_reg),
        .short_ticks (short_ticks_reg),
        .alert_ticks (alert_ticks_reg),
        .batch       (batch)
    );

    rcc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .batch    (batch),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/rcc_checker.sv
// Port-level checks for the registration and call controller, bound to the top level.
module rcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);
    import rcc_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an empty result is the only result of its request
    a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == M_NONE |-> m_tlast)
        else $error("empty result not last");

    // cause only on disconnect or release response
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[43:36] != 8'd0 |-> m_tdata[3:0] == M_DISC
                                               || m_tdata[3:0] == M_RELRSP)
        else $error("cause on wrong message");

    // states legal
    a_states: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[45:44] != 2'd3 && m_tdata[49:46] <= C_RELEASING)
        else $error("illegal state reported");

endmodule

bind registration_and_call_control_fsm rcc_checker u_rcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> dv/rcc_signaling_checker.sv
// Checker for the registration and call controller: predicts outgoing messages and compares them.
module rcc_signaling_checker
    import rcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,    // msg_type, call_id
    input  logic [2:0]  s_tuser,    // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,    // send_message, out_call_id, out_cause,
                                    // reg_status, call_status, zero pad
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          awaited,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  msg;
        logic [31:0] id;
        logic [7:0]  cause;
        logic [1:0]  reg_st;
        logic [3:0]  call_st;
        logic        last;
    } outgoing_t;

    typedef enum int {T_REG, T_SETUP, T_ALERT_WAIT, T_ANSWER, T_DISC, T_CONN} timer_e;

    typedef struct packed {
        logic [15:0] count;
        logic        run;
        logic        due;
    } timer_t;

    logic [15:0] short_ticks;
    logic [15:0] alert_ticks;
    logic [1:0]  reg_phase;
    logic [3:0]  call_phase;
    logic [1:0]  init_tries;
    logic [1:0]  auth_tries;
    logic [1:0]  dereg_tries;
    logic [1:0]  conn_tries;
    logic        disc_tries;
    logic [31:0] call_id_q;
    logic [7:0]  disc_cause;
    timer_t      timers [6];

    outgoing_t   batch [MAX_RES];
    int          batch_n;
    outgoing_t   awaited_msgs [$];
    outgoing_t   got;
    outgoing_t   want;

    function automatic void queue_msg(logic [3:0] m, logic [31:0] id, logic [7:0] c);
        if (batch_n < MAX_RES)
        begin
            batch[batch_n]       = '0;
            batch[batch_n].msg   = m;
            batch[batch_n].id    = id;
            batch[batch_n].cause = c;
            batch_n++;
        end
    endfunction

    function automatic void arm(timer_e t, logic [15:0] v);
        timers[t].count = v;
        timers[t].run   = 1'b1;
    endfunction

    function automatic void halt(timer_e t);
        timers[t] = '0;
    endfunction

    function automatic void count_down(timer_e t);
        timers[t].due = 1'b0;
        if (timers[t].run)
        begin
            if (timers[t].count <= 16'd1)
            begin
                timers[t].count = '0;
                timers[t].due   = 1'b1;
            end
            else
                timers[t].count = timers[t].count - 16'd1;
        end
    endfunction

    function automatic logic expired(timer_e t);
        logic f;
        f = timers[t].due && timers[t].run;
        timers[t].due = 1'b0;
        return f;
    endfunction

    function automatic void drop_registration();
        halt(T_REG);
        reg_phase   = R_UNREG;
        call_phase  = C_IDLE;
        init_tries  = '0;
        auth_tries  = '0;
        dereg_tries = '0;
        conn_tries  = '0;
        disc_tries  = 1'b0;
    endfunction

    function automatic void clear_call();
        call_phase = C_IDLE;
        conn_tries = '0;
        disc_tries = 1'b0;
        halt(T_SETUP);
        halt(T_ALERT_WAIT);
        halt(T_ANSWER);
        halt(T_DISC);
        halt(T_CONN);
    endfunction

    function automatic void drop_setup();
        halt(T_SETUP);
        halt(T_ALERT_WAIT);
        halt(T_ANSWER);
        call_phase = C_IDLE;
        conn_tries = '0;
        disc_tries = 1'b0;
    endfunction

    // each registration phase gets two resends before giving up
    function automatic void registration_timeout();
        halt(T_REG);
        case (reg_phase)
            R_UNREG:
                if (init_tries <= 2'd1)
                begin
                    init_tries++;
                    arm(T_REG, short_ticks);
                    queue_msg(M_REG, '0, '0);
                end
                else
                    drop_registration();
            R_AUTH:
                if (auth_tries <= 2'd1)
                begin
                    auth_tries++;
                    arm(T_REG, short_ticks);
                    queue_msg(M_AUTHREG, '0, '0);
                end
                else
                    drop_registration();
            default:
                if (dereg_tries <= 2'd1)
                begin
                    dereg_tries++;
                    arm(T_REG, short_ticks);
                    queue_msg(M_DEREGREQ, '0, '0);
                end
                else
                    drop_registration();
        endcase
    endfunction

    // expiries handled in fixed order; a handler may stop a later timer
    function automatic void tick_all();
        for (int i = 0; i < 6; i++)
            count_down(timer_e'(i));
        if (expired(T_REG))
            registration_timeout();
        if (expired(T_SETUP))
            drop_setup();
        if (expired(T_ALERT_WAIT))
            drop_setup();
        if (expired(T_ANSWER))
            drop_setup();
        if (expired(T_DISC))
        begin
            halt(T_DISC);
            if (disc_tries == 1'b0)
            begin
                disc_tries = 1'b1;
                arm(T_DISC, short_ticks);
                queue_msg(M_DISC, call_id_q, disc_cause);
            end
            else
                clear_call();
        end
        if (expired(T_CONN))
        begin
            halt(T_CONN);
            if (conn_tries <= 2'd1)
            begin
                conn_tries++;
                arm(T_CONN, short_ticks);
                queue_msg(M_CONNECT, call_id_q, '0);
            end
            else
            begin
                conn_tries = '0;
                disc_tries = 1'b0;
                disc_cause = CAUSE_NO_ANSWER;
                arm(T_DISC, short_ticks);
                call_phase = C_RELEASING;
                queue_msg(M_DISC, call_id_q, disc_cause);
            end
        end
    endfunction

    function automatic void receive_msg(logic [7:0] mt, logic [31:0] id);
        halt(T_REG);
        if (mt == MT_AUTH_CMD && reg_phase == R_UNREG)
        begin
            reg_phase = R_AUTH;
            arm(T_REG, short_ticks);
            queue_msg(M_AUTHREG, '0, '0);
        end
        else if (mt == MT_REG_RSP && reg_phase == R_AUTH)
        begin
            reg_phase  = R_REG;
            call_phase = C_IDLE;
        end
        else if (mt == MT_DEREG_REQ && reg_phase == R_REG)
        begin
            queue_msg(M_DEREGRSP, '0, '0);
            drop_registration();
        end
        else if (mt == MT_DEREG_RSP && reg_phase == R_REG)
            drop_registration();
        else if (mt == MT_SETUP && call_phase == C_IDLE && reg_phase == R_REG)
        begin
            call_id_q = id;
            queue_msg(M_SETUPACK, call_id_q, '0);
            queue_msg(M_ALERT, call_id_q, '0);
            call_phase = C_RECV;
        end
        else if (mt == MT_SETUP_ACK && call_phase == C_INIT)
        begin
            call_phase = C_PROC;
            halt(T_SETUP);
            call_id_q = id;
            arm(T_ALERT_WAIT, short_ticks);
        end
        else if (mt == MT_ALERTING && call_phase == C_PROC)
        begin
            call_phase = C_DELIV;
            halt(T_ALERT_WAIT);
            halt(T_SETUP);
            arm(T_ANSWER, alert_ticks);
        end
        else if (mt == MT_CONNECT && (call_phase == C_DELIV || call_phase == C_PROC))
        begin
            call_phase = C_ACTIVE;
            halt(T_ANSWER);
            halt(T_SETUP);
            halt(T_ALERT_WAIT);
            queue_msg(M_CONNACK, call_id_q, '0);
        end
        else if (mt == MT_CONN_ACK && call_phase == C_CONREQ)
        begin
            call_phase = C_ACTIVE;
            halt(T_CONN);
            conn_tries = '0;
            disc_tries = 1'b0;
        end
        else if (mt == MT_REL_REQ)
        begin
            clear_call();
            queue_msg(M_RELRSP, call_id_q, CAUSE_NORMAL);
        end
    endfunction

    // hang-up from delivered keeps whatever cause was last set
    function automatic void user_disconnect(logic set_cause, logic [7:0] cause);
        disc_tries = 1'b0;
        halt(T_ANSWER);
        arm(T_DISC, short_ticks);
        call_phase = C_RELEASING;
        if (set_cause)
            disc_cause = cause;
        queue_msg(M_DISC, call_id_q, disc_cause);
    endfunction

    function automatic void predict_signaling(logic [2:0] kind, logic [7:0] mt,
                                              logic [31:0] id);
        outgoing_t o;
        batch_n = 0;
        case (kind)
            KIND_RX:
                receive_msg(mt, id);
            KIND_REG:
                if (reg_phase == R_UNREG)
                begin
                    arm(T_REG, short_ticks);
                    queue_msg(M_REG, '0, '0);
                end
            KIND_DEREG:
                if (reg_phase == R_REG)
                begin
                    arm(T_REG, short_ticks);
                    queue_msg(M_DEREGREQ, '0, '0);
                end
            KIND_CALL:
                if (reg_phase == R_REG && call_phase == C_IDLE)
                begin
                    call_phase = C_INIT;
                    arm(T_SETUP, short_ticks);
                    queue_msg(M_SETUP, CALL_ID_NONE, '0);
                end
            KIND_HANGUP:
                if (call_phase == C_DELIV)
                    user_disconnect(1'b0, '0);
                else if (call_phase == C_ACTIVE)
                    user_disconnect(1'b1, CAUSE_NORMAL);
                else if (call_phase == C_RECV)
                    user_disconnect(1'b1, CAUSE_REJECT);
            KIND_ANSWER:
                if (call_phase == C_RECV)
                begin
                    arm(T_CONN, short_ticks);
                    call_phase = C_CONREQ;
                    queue_msg(M_CONNECT, call_id_q, '0);
                end
            KIND_TICK:
                tick_all();
            default:
                ;
        endcase
        if (batch_n == 0)
            queue_msg(M_NONE, '0, '0);
        for (int k = 0; k < batch_n; k++)
        begin
            o         = batch[k];
            o.reg_st  = reg_phase;
            o.call_st = call_phase;
            o.last    = (k == batch_n - 1);
            awaited_msgs.push_back(o);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ticks = SHORT_TICKS_RST;
            alert_ticks = ALERT_TICKS_RST;
            reg_phase   = R_UNREG;
            call_phase  = C_IDLE;
            init_tries  = '0;
            auth_tries  = '0;
            dereg_tries = '0;
            conn_tries  = '0;
            disc_tries  = 1'b0;
            for (int i = 0; i < 6; i++)
                timers[i] = '0;
            call_id_q   = CALL_ID_NONE;
            disc_cause  = CAUSE_NORMAL;
            awaited_msgs.delete();
            mismatches  = 0;
            awaited     = 0;
            checked     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.msg     = m_tdata[3:0];
                got.id      = m_tdata[35:4];
                got.cause   = m_tdata[43:36];
                got.reg_st  = m_tdata[45:44];
                got.call_st = m_tdata[49:46];
                got.last    = m_tlast;
                checked++;
                if (awaited_msgs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t unexpected message %0d id %h cause %0d", $realtime,
                                 got.msg, got.id, got.cause);
                end
                else
                begin
                    want = awaited_msgs.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%t mismatch: exp msg %0d id %h cause %0d reg %0d ",
                                      "call %0d last %0d, got msg %0d id %h cause %0d ",
                                      "reg %0d call %0d last %0d"}, $realtime,
                                     want.msg, want.id, want.cause, want.reg_st,
                                     want.call_st, want.last, got.msg, got.id, got.cause,
                                     got.reg_st, got.call_st, got.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SHORT)
                    short_ticks = cfg_data;
                else
                    alert_ticks = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_signaling(s_tuser, s_tdata[7:0], s_tdata[39:8]);
            awaited = awaited_msgs.size();
        end
    end

endmodule

>>> dv/registration_and_call_control_fsm_test.sv
// Testbench top: drives requests and timer settings into the controller and reports the verdict.
module registration_and_call_control_fsm_test
    import rcc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_NONE = 3'd7;    // ignored by the block

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // msg_type, call_id
    logic [2:0]  s_tuser;     // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;     // send_message, out_call_id, out_cause,
                              // reg_status, call_status, zero pad
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int          mismatches;
    int          awaited;
    int          checked;
    int          sent;
    int          counted;
    int          writes;
    logic [15:0] cur_short;
    bit          idle_allowed;

    registration_and_call_control_fsm #(.TIMER_BITS(16)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rcc_signaling_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (idle_allowed && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 9))
                    @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CALL_ID_NONE;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_req(input logic [2:0] kind, input logic [7:0] mt,
                            input logic [31:0] id);
        if (idle_allowed && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9))
                @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {id, mt};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent++;
        if (kind != KIND_NONE && (kind != KIND_RX ||
            mt inside {MT_AUTH_CMD, MT_REG_RSP, MT_DEREG_REQ, MT_DEREG_RSP, MT_SETUP,
                       MT_SETUP_ACK, MT_ALERTING, MT_CONNECT, MT_CONN_ACK, MT_REL_REQ}))
            counted++;
    endtask

    // one step of a flow: maybe a few ticks first, occasionally dropped
    task automatic step(input logic [2:0] kind, input logic [7:0] mt, input logic [31:0] id);
        int ticks;
        ticks = 0;
        if ($urandom_range(0, 3) == 0)
            ticks = $urandom_range(0, (cur_short < 16'd6) ? int'(cur_short) + 1 : 2);
        repeat (ticks)
            send_req(KIND_TICK, 8'($urandom), $urandom);
        if ($urandom_range(0, 9) != 0)
            send_req(kind, mt, id);
    endtask

    task automatic settle();
        int guard;
        s_tvalid = 1'b0;
        guard    = 0;
        while (awaited != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        writes++;
        if (idx == CFG_SHORT)
            cur_short = val;
    endtask

    task automatic run_flow();
        logic [31:0] cid;
        cid = pick_id();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                step(KIND_REG, 8'($urandom), $urandom);
                step(KIND_RX, MT_AUTH_CMD, cid);
                step(KIND_RX, MT_REG_RSP, cid);
            end
            2, 3:
            begin
                step(KIND_CALL, 8'($urandom), $urandom);
                step(KIND_RX, MT_SETUP_ACK, cid);
                if ($urandom_range(0, 2) != 0)
                    step(KIND_RX, MT_ALERTING, cid);
                step(KIND_RX, MT_CONNECT, cid);
                if ($urandom_range(0, 1) != 0)
                    step(KIND_HANGUP, 8'($urandom), $urandom);
                else
                    step(KIND_RX, MT_REL_REQ, cid);
            end
            4, 5:
            begin
                step(KIND_RX, MT_SETUP, cid);
                if ($urandom_range(0, 2) != 0)
                begin
                    step(KIND_ANSWER, 8'($urandom), $urandom);
                    step(KIND_RX, MT_CONN_ACK, cid);
                end
                if ($urandom_range(0, 1) != 0)
                    step(KIND_HANGUP, 8'($urandom), $urandom);
                else
                    step(KIND_RX, MT_REL_REQ, cid);
            end
            6:
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    step(KIND_DEREG, 8'($urandom), $urandom);
                    step(KIND_RX, MT_DEREG_RSP, cid);
                end
                else
                    step(KIND_RX, MT_DEREG_REQ, cid);
            end
            7:
                repeat ($urandom_range(1, 8))
                    send_req(KIND_TICK, 8'($urandom), $urandom);
            default:
                send_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), cid);
        endcase
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = KIND_NONE;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_SHORT;
        cfg_data     = '0;
        sent         = 0;
        counted      = 0;
        writes       = 0;
        cur_short    = SHORT_TICKS_RST;
        idle_allowed = 1'b1;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: one-tick timers so every timeout is reachable quickly
        cfg_write(CFG_SHORT, 16'd1);
        cfg_write(CFG_ALERT, 16'd1);
        send_req(KIND_NONE, 8'hff, CALL_ID_NONE);
        send_req(KIND_RX, 8'h00, 32'h0);
        send_req(KIND_RX, 8'hff, CALL_ID_NONE);
        send_req(KIND_REG, 8'h00, 32'h0);
        send_req(KIND_TICK, 8'h00, 32'h0);           // first resend of register
        send_req(KIND_TICK, 8'hff, CALL_ID_NONE);    // second resend
        send_req(KIND_TICK, 8'h00, 32'h0);           // gives up
        send_req(KIND_REG, 8'h00, 32'h0);
        send_req(KIND_RX, MT_AUTH_CMD, 32'h0);
        send_req(KIND_TICK, 8'h00, 32'h0);           // auth register resent
        send_req(KIND_RX, MT_REG_RSP, 32'h0);
        send_req(KIND_CALL, 8'h00, 32'h0);
        send_req(KIND_RX, MT_SETUP_ACK, 32'h0);
        send_req(KIND_RX, MT_ALERTING, CALL_ID_NONE);
        send_req(KIND_RX, MT_CONNECT, CALL_ID_NONE);
        send_req(KIND_HANGUP, 8'h00, 32'h0);         // normal clearing from active
        send_req(KIND_TICK, 8'h00, 32'h0);           // disconnect resent
        send_req(KIND_TICK, 8'h00, 32'h0);           // call released
        send_req(KIND_RX, MT_SETUP, CALL_ID_NONE);
        send_req(KIND_ANSWER, 8'hff, 32'h0);
        send_req(KIND_TICK, 8'h00, 32'h0);           // connect resent
        send_req(KIND_RX, MT_CONN_ACK, 32'h0);
        send_req(KIND_RX, MT_REL_REQ, 32'h0);
        send_req(KIND_RX, MT_SETUP, 32'ha5a5_5a5a);
        send_req(KIND_HANGUP, 8'h00, 32'h0);         // rejected incoming call
        send_req(KIND_DEREG, 8'h00, 32'h0);
        send_req(KIND_RX, MT_DEREG_RSP, 32'h0);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    cfg_write(CFG_SHORT, 16'd1);
                    cfg_write(CFG_ALERT, 16'd1);
                end
                1:
                begin
                    cfg_write(CFG_SHORT, 16'd2);
                    cfg_write(CFG_ALERT, 16'hffff);
                end
                2:
                begin
                    cfg_write(CFG_SHORT, 16'd3);
                    cfg_write(CFG_ALERT, 16'd7);
                end
                3:
                begin
                    cfg_write(CFG_SHORT, 16'hffff);
                    cfg_write(CFG_ALERT, 16'hffff);
                end
                4:
                begin
                    cfg_write(CFG_SHORT, 16'($urandom_range(1, 6)));
                    cfg_write(CFG_ALERT, 16'($urandom_range(1, 12)));
                end
                default:
                begin
                    idle_allowed = 1'b0;
                    cfg_write(CFG_SHORT, 16'd1);
                    cfg_write(CFG_ALERT, 16'd2);
                end
            endcase
            while (counted < 28 + 64 * (ph + 1))
                run_flow();
            settle();
        end

        $display("covered %0d requests (%0d acted upon), %0d results checked", sent, counted,
                 checked);
        $display("%0d timer register writes, settings from 1 to 65535 ticks", writes);
        if (mismatches == 0 && awaited == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> registration_and_call_control_fsm.f
rtl/rcc_pkg.sv
rtl/rcc_ctrl.sv
rtl/rcc_outq.sv
rtl/registration_and_call_control_fsm.sv
rtl/rcc_checker.sv
dv/rcc_signaling_checker.sv
dv/registration_and_call_control_fsm_test.sv
